/* sv/lfb_pkg.sv */
// Shared types and constants for the flag-byte LZSS decompressor.
// No dependencies; the files that use this package refer to it by scoped names.
package lfb_pkg;

    // History window and field widths
    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 31;
    localparam int LEN_W            = 5;
    localparam int OFFSET_SHIFT     = 4;

    // Token format constants
    localparam logic [3:0]       LEN_FIELD_MASK  = 4'hF;
    localparam logic [LEN_W-1:0] LEN_BIAS        = 5'd2;
    localparam logic [3:0]       TOKENS_PER_FLAG = 4'd8;

    // Parser position within the compressed stream
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_REFHI = 2'd2
    } phase_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_LIT
    } state_t;

    // What to do with an accepted input byte
    typedef enum logic [2:0] {
        OP_NONE,
        OP_FLAG,
        OP_LOW,
        OP_REF,
        OP_LIT
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t  op;
        logic read;
        logic emit;
        logic emit_lit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic phase_refhi;
        logic token_ok;
        logic flag_lsb;
        logic out_free;
        logic copy_last;
    } status_t;

endpackage

/* sv/lfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lfb_ctrl.sv */
// Controller state machine: parses input requests and sequences copies.
// Depends on lfb_pkg.
module lfb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lfb_pkg::status_t status,
    output lfb_pkg::cmd_t    cmd
);

    lfb_pkg::state_t state_reg;
    lfb_pkg::state_t state_next;
    logic            take;

    assign take     = s_tvalid && (state_reg == lfb_pkg::ST_IDLE) && !status.done;
    assign s_tready = (state_reg == lfb_pkg::ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfb_pkg::ST_IDLE:
            begin
                if (take && status.phase_refhi)
                begin
                    state_next = lfb_pkg::ST_READ;
                end
                else if (take && status.token_ok && status.flag_lsb)
                begin
                    state_next = lfb_pkg::ST_LIT;
                end
            end
            lfb_pkg::ST_READ:
            begin
                state_next = lfb_pkg::ST_COPY;
            end
            lfb_pkg::ST_COPY:
            begin
                if (status.out_free)
                begin
                    state_next = status.copy_last ? lfb_pkg::ST_IDLE : lfb_pkg::ST_READ;
                end
            end
            lfb_pkg::ST_LIT:
            begin
                if (status.out_free)
                begin
                    state_next = lfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        cmd.op = lfb_pkg::OP_NONE;
        unique case (state_reg)
            lfb_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (status.phase_refhi)
                    begin
                        cmd.op = lfb_pkg::OP_REF;
                    end
                    else if (status.token_ok)
                    begin
                        cmd.op = status.flag_lsb ? lfb_pkg::OP_LIT : lfb_pkg::OP_LOW;
                    end
                    else
                    begin
                        cmd.op = lfb_pkg::OP_FLAG;
                    end
                end
            end
            lfb_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            lfb_pkg::ST_COPY:
            begin
                cmd.emit = status.out_free;
            end
            lfb_pkg::ST_LIT:
            begin
                cmd.emit     = status.out_free;
                cmd.emit_lit = 1'b1;
            end
            default:
            begin
                cmd.op = lfb_pkg::OP_NONE;
            end
        endcase
    end

endmodule

/* sv/lfb_datapath.sv */
// Datapath: parse registers, history window, byte counters and output register.
// Depends on lfb_pkg and lfb_ram.
module lfb_datapath #(
    parameter int WINDOW_DEPTH = lfb_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfb_pkg::cmd_t                 cmd,
    output lfb_pkg::status_t              status,
    input  logic [lfb_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          cfg_we,
    input  logic [lfb_pkg::COUNT_W-1:0]   cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lfb_pkg::BYTE_W-1:0]    m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WINDOW_DEPTH - 1);

    // Parser state
    lfb_pkg::phase_t                   phase_reg, phase_next;
    logic [lfb_pkg::BYTE_W-1:0]        flag_reg, flag_next;
    logic [3:0]                        tokens_reg, tokens_next;
    logic [lfb_pkg::BYTE_W-1:0]        lo_reg, lo_next;
    // Copy in progress
    logic [lfb_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [ADDR_W-1:0]                 dist_reg, dist_next;
    logic [lfb_pkg::BYTE_W-1:0]        lit_reg, lit_next;
    logic                              hit_reg, hit_next;
    // Window fill tracking
    logic [ADDR_W-1:0]                 wp_reg, wp_next;
    logic                              wrapped_reg, wrapped_next;
    // Stream length
    logic [lfb_pkg::COUNT_W-1:0]       bytes_reg, bytes_next;
    logic [lfb_pkg::COUNT_W-1:0]       olen_reg, olen_next;
    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [lfb_pkg::BYTE_W-1:0]        out_byte_reg, out_byte_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_end_reg, out_end_next;

    logic [15:0]                       word;
    logic [ADDR_W-1:0]                 rd_addr;
    logic [lfb_pkg::BYTE_W-1:0]        rd_data;
    logic [lfb_pkg::BYTE_W-1:0]        emit_byte;
    logic [lfb_pkg::COUNT_W-1:0]       bytes_inc;
    logic [3:0]                        tokens_dec;
    logic                              end_hit;
    logic                              emit_last;

    // History window
    lfb_ram #(
        .DATA_W (lfb_pkg::BYTE_W),
        .DEPTH  (WINDOW_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.emit),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (cmd.read),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Shared combinational terms
    assign word       = {in_byte, lo_reg};
    assign rd_addr    = wp_reg - dist_reg;
    assign bytes_inc  = bytes_reg + lfb_pkg::COUNT_W'(1);
    assign tokens_dec = tokens_reg - 4'd1;
    assign end_hit    = (bytes_inc >= olen_reg);
    assign emit_last  = cmd.emit_lit || status.copy_last;
    // slots not yet written since reset read as zero
    assign emit_byte  = cmd.emit_lit ? lit_reg : (hit_reg ? rd_data : '0);

    // Status to controller
    always_comb
    begin
        status.done        = (bytes_reg >= olen_reg);
        status.phase_refhi = (phase_reg == lfb_pkg::PH_REFHI);
        status.token_ok    = (phase_reg == lfb_pkg::PH_TOKEN) && (tokens_reg != 4'd0);
        status.flag_lsb    = flag_reg[0];
        status.out_free    = !out_valid_reg || m_tready;
        status.copy_last   = (len_reg == lfb_pkg::LEN_W'(1)) || end_hit;
    end

    // Next-state logic
    always_comb
    begin
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        tokens_next    = tokens_reg;
        lo_next        = lo_reg;
        len_next       = len_reg;
        dist_next      = dist_reg;
        lit_next       = lit_reg;
        hit_next       = hit_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        bytes_next     = bytes_reg;
        olen_next      = olen_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;

        // accepted input byte
        case (cmd.op)
            lfb_pkg::OP_FLAG:
            begin
                flag_next   = in_byte;
                tokens_next = lfb_pkg::TOKENS_PER_FLAG;
                phase_next  = lfb_pkg::PH_TOKEN;
            end
            lfb_pkg::OP_LOW:
            begin
                lo_next    = in_byte;
                phase_next = lfb_pkg::PH_REFHI;
            end
            lfb_pkg::OP_REF:
            begin
                len_next  = lfb_pkg::LEN_W'(word[3:0] & lfb_pkg::LEN_FIELD_MASK)
                            + lfb_pkg::LEN_BIAS;
                dist_next = word[lfb_pkg::OFFSET_SHIFT +: ADDR_W];
            end
            lfb_pkg::OP_LIT:
            begin
                lit_next = in_byte;
            end
            default:
            begin
                lit_next = lit_reg;
            end
        endcase

        // history read for one copy byte
        if (cmd.read)
        begin
            hit_next = wrapped_reg || (rd_addr < wp_reg);
        end

        // output register drains
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // one byte emitted
        if (cmd.emit)
        begin
            wp_next        = wp_reg + ADDR_W'(1);
            wrapped_next   = wrapped_reg || (wp_reg == ADDR_LAST);
            bytes_next     = bytes_inc;
            len_next       = len_reg - lfb_pkg::LEN_W'(1);
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
            out_end_next   = end_hit;
            if (emit_last)
            begin
                flag_next   = flag_reg >> 1;
                tokens_next = tokens_dec;
                phase_next  = (tokens_dec == 4'd0) ? lfb_pkg::PH_FLAG : lfb_pkg::PH_TOKEN;
                if (end_hit)
                begin
                    phase_next = lfb_pkg::PH_FLAG;
                end
            end
        end

        if (cfg_we)
        begin
            olen_next = cfg_wdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lfb_pkg::PH_FLAG;
            flag_reg      <= '0;
            tokens_reg    <= '0;
            len_reg       <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            bytes_reg     <= '0;
            olen_reg      <= lfb_pkg::COUNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            tokens_reg    <= tokens_next;
            len_reg       <= len_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            bytes_reg     <= bytes_next;
            olen_reg      <= olen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        dist_reg     <= dist_next;
        lit_reg      <= lit_next;
        hit_reg      <= hit_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule

/* sv/lzss_flag_byte_decompressor.sv */
// Top level of the flag-byte LZSS decompressor with a 4 KiB history window.
// Depends on lfb_pkg, lfb_ctrl, lfb_datapath (and lfb_ram below it).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] = in_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata[7:0] = out_byte, m_tlast = run_last,
//          |     |                    | m_tuser = stream_end
//  cfg_    | in  | cfg_we             | cfg_wdata[30:0] = output_length
//
// A flag byte or reference low byte is handled in the idle state alone; a
// literal then passes through the literal state. A reference goes through the
// read and copy states for each copied byte (history read, then emit), as the
// window RAM read is registered. No clearing pass after reset: a fill pointer
// and wrap bit make unwritten slots read as zero, so requests are taken at once.
// A stalled output holds the next emit; the output register lets one result
// wait while the block goes on parsing bytes that produce nothing.
module lzss_flag_byte_decompressor #(
    parameter int WINDOW_DEPTH = lfb_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // compressed input: [7:0] in_byte
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    // decompressed output: [7:0] out_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    // [0] stream_end
    output logic                        m_tuser,
    // output_length register
    input  logic                        cfg_we,
    input  logic [lfb_pkg::COUNT_W-1:0] cfg_wdata
);

    lfb_pkg::cmd_t    cmd;
    lfb_pkg::status_t status;

    lfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lfb_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // An emit never overwrites a result that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register occupied");

    // The byte that ends the stream is always the last of its run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream end without run end");

    // A request taken after completion produces nothing
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && status.done |=> !cmd.emit && !cmd.read)
        else $error("output after stream completion");

    // A history read is always followed by its copy step
    a_read_copy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> !cmd.read && !s_tready)
        else $error("history read not followed by copy");

endmodule
